>>> design/bnu_pkg.sv
// Shared types, constants and table builder for the backpropagation neuron unit.
package bnu_pkg;

    localparam int FRAC_BITS       = 12;
    localparam int MAX_INPUTS      = 64;
    localparam int SLOT_W          = $clog2(MAX_INPUTS);
    localparam int DATA_W          = 16;
    localparam int INDEX_W         = 6;
    localparam int CFG_W           = 13;
    localparam int CFG_IDX_W       = 1;
    localparam int ACC_W           = 40;
    localparam int ACC_Q_W         = ACC_W - FRAC_BITS;
    localparam int DER_W           = FRAC_BITS + 2;
    localparam int MUL_A_W         = 30;
    localparam int MUL_B_W         = 17;
    localparam int PROD_W          = MUL_A_W + MUL_B_W;
    localparam int STEP_W          = 24;
    localparam int SAT_W           = 48;
    localparam int TANH_DEPTH      = 256;
    localparam int TANH_DEPTH_LOG2 = $clog2(TANH_DEPTH);
    localparam int TANH_SPAN       = 8;
    localparam int TANH_SPAN_LOG2  = $clog2(TANH_SPAN);
    localparam int TANH_W          = FRAC_BITS + 1;

    localparam logic [CFG_W-1:0] LR_RESET  = CFG_W'(205);
    localparam logic [CFG_W-1:0] MOM_RESET = CFG_W'(2048);
    localparam logic signed [DATA_W-1:0] WEIGHT_RESET = DATA_W'(1 << (FRAC_BITS - 1));

    typedef enum logic [1:0] {
        MODE_FORWARD  = 2'd0,
        MODE_OUT_GRAD = 2'd1,
        MODE_HID_GRAD = 2'd2,
        MODE_UPDATE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_OUTPUT   = 2'd0,
        KIND_GRADIENT = 2'd1,
        KIND_WEIGHT   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE = 1'd0,
        CFG_MOMENTUM      = 1'd1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_FWD_MUL,
        S_FWD_ACC,
        S_TANH,
        S_TANH_WR,
        S_HID_MUL,
        S_HID_ACC,
        S_DER_MUL,
        S_DER_SUB,
        S_GRAD_MUL,
        S_GRAD_SAT,
        S_UPD_MUL1,
        S_UPD_MUL2,
        S_UPD_MUL3,
        S_UPD_CHG,
        S_UPD_WR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] data_value;
        logic signed [DATA_W-1:0] downstream_weight;
        logic [INDEX_W-1:0]       element_index;
        logic                     last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               result_kind;
        logic [INDEX_W-1:0]       result_index;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] change;
        logic signed [DATA_W-1:0] weight;
    } t_mem_word;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        t_mem_word         data;
    } t_mem_wr;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] value;
    } t_sat;

    typedef logic [TANH_W-1:0] t_tanh_tab [TANH_DEPTH];

    // Clip to the signed 16 bit range and flag the clip.
    function automatic t_sat sat16(input logic signed [SAT_W-1:0] v);
        t_sat s;
        s.clip  = 1'b0;
        s.value = DATA_W'(v);
        if (v > SAT_W'(32767)) begin
            s.clip  = 1'b1;
            s.value = 16'sh7FFF;
        end else if (v < -SAT_W'(32768)) begin
            s.clip  = 1'b1;
            s.value = 16'sh8000;
        end
        return s;
    endfunction

    // Restoring division, elaboration use only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Tanh magnitudes over [0, TANH_SPAN) in Q32 integer arithmetic.
    function automatic t_tanh_tab build_tanh();
        t_tanh_tab   tab;
        logic [63:0] one32;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] base;
        logic [63:0] p;
        logic [63:0] num;
        logic [63:0] den;
        one32 = 64'h1_0000_0000;
        t     = udiv64(64'(2 * TANH_SPAN) << 32, 64'(TANH_DEPTH));
        pos   = one32;
        neg   = '0;
        term  = one32;
        for (int k = 1; k <= 24; k++) begin
            term = udiv64((term * t) >> 32, 64'(k));
            if ((k % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        base = pos - neg;
        p    = one32;
        for (int i = 0; i < TANH_DEPTH; i++) begin
            num    = one32 - p;
            den    = one32 + p;
            tab[i] = TANH_W'(udiv64((num << FRAC_BITS) + (den >> 1), den));
            p      = (p * base) >> 32;
        end
        return tab;
    endfunction

endpackage

>>> design/backprop_neuron_unit.sv
// Top level of the backpropagation neuron unit: sequencer, state and handshakes.
//
// One tanh neuron in signed Q4.12 with a 64-slot weight store and momentum. Every
// transaction goes through one shared 30x17 multiplier, one product per cycle, so the
// time a transaction takes is set by how many products it needs, by the registered
// read of the slot store and by any wait on i_out_stall while an earlier result is
// still held. Only one transaction is in work at a time; o_in_stall is high meanwhile.
// After reset the slot store is swept to weights of 0.5 and changes of zero, during
// which no transaction is accepted; configuration writes are taken at any time and
// must only be issued while the unit is idle.
module backprop_neuron_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bnu_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bnu_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [bnu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bnu_pkg::CFG_W-1:0]           i_cfg_wdata
);

    localparam logic signed [bnu_pkg::ACC_W-1:0] ACC_MAX =
        {1'b0, {(bnu_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [bnu_pkg::ACC_W-1:0] ACC_MIN =
        {1'b1, {(bnu_pkg::ACC_W-1){1'b0}}};
    localparam logic signed [bnu_pkg::DER_W-1:0] ONE_D =
        bnu_pkg::DER_W'(1 << bnu_pkg::FRAC_BITS);

    bnu_pkg::t_state                        r_state, n_state;
    bnu_pkg::t_in_item                      r_item, n_item;
    logic signed [bnu_pkg::ACC_W-1:0]       r_acc, n_acc;
    logic signed [bnu_pkg::DATA_W-1:0]      r_out, n_out;
    logic signed [bnu_pkg::DATA_W-1:0]      r_grad, n_grad;
    logic signed [bnu_pkg::DER_W-1:0]       r_d, n_d;
    logic signed [bnu_pkg::STEP_W-1:0]      r_step, n_step;
    logic signed [bnu_pkg::DATA_W-1:0]      r_chg, n_chg;
    logic signed [bnu_pkg::DATA_W-1:0]      r_res, n_res;
    logic                                   r_clip, n_clip;
    bnu_pkg::t_kind                         r_kind, n_kind;
    logic [bnu_pkg::INDEX_W-1:0]            r_ridx, n_ridx;
    logic [bnu_pkg::CFG_W-1:0]              r_eta, n_eta;
    logic [bnu_pkg::CFG_W-1:0]              r_alpha, n_alpha;
    logic                                   r_out_valid, n_out_valid;
    bnu_pkg::t_out_item                     r_out_data, n_out_data;

    logic signed [bnu_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [bnu_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [bnu_pkg::PROD_W-1:0]      prod;
    bnu_pkg::t_mem_wr                       mem_wr;
    bnu_pkg::t_mem_word                     mem_rd;
    logic                                   mem_busy;
    logic signed [bnu_pkg::DATA_W-1:0]      tanh_y;
    logic [bnu_pkg::SLOT_W-1:0]             slot;

    logic                                   in_accept;
    logic                                   out_free;
    logic signed [bnu_pkg::ACC_W:0]         acc_sum;
    logic signed [bnu_pkg::ACC_W-1:0]       acc_sat;
    logic signed [bnu_pkg::MUL_B_W-1:0]     delta;
    logic signed [bnu_pkg::ACC_Q_W-1:0]     acc_q;
    bnu_pkg::t_sat                          grad_sat;
    bnu_pkg::t_sat                          chg_sat;
    bnu_pkg::t_sat                          w_sat;

    bnu_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    bnu_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (mem_wr),
        .i_raddr (slot),
        .o_rdata (mem_rd),
        .o_busy  (mem_busy)
    );

    bnu_tanh u_tanh (
        .i_clk (i_clk),
        .i_acc (r_acc),
        .o_y   (tanh_y)
    );

    // Slot index wraps at the store depth; the read port follows the held transaction.
    assign slot       = r_item.element_index[bnu_pkg::SLOT_W-1:0];
    assign o_in_stall = (r_state != bnu_pkg::S_IDLE) || mem_busy;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Datapath terms shared by several steps.
    always_comb begin
        acc_sum = (bnu_pkg::ACC_W + 1)'(r_acc) + (bnu_pkg::ACC_W + 1)'(signed'(prod[31:0]));
        if (acc_sum[bnu_pkg::ACC_W] != acc_sum[bnu_pkg::ACC_W-1]) begin
            acc_sat = acc_sum[bnu_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_sat = acc_sum[bnu_pkg::ACC_W-1:0];
        end
        delta    = bnu_pkg::MUL_B_W'(r_item.data_value) - bnu_pkg::MUL_B_W'(r_out);
        acc_q    = bnu_pkg::ACC_Q_W'(r_acc >>> bnu_pkg::FRAC_BITS);
        grad_sat = bnu_pkg::sat16(bnu_pkg::SAT_W'(prod >>> bnu_pkg::FRAC_BITS));
        chg_sat  = bnu_pkg::sat16(bnu_pkg::SAT_W'(r_step)
                                  + bnu_pkg::SAT_W'(prod >>> bnu_pkg::FRAC_BITS));
        w_sat    = bnu_pkg::sat16(bnu_pkg::SAT_W'(mem_rd.weight) + bnu_pkg::SAT_W'(r_chg));
    end

    // Multiplier operand selection: one product per sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            bnu_pkg::S_FWD_MUL: begin
                mul_a = bnu_pkg::MUL_A_W'(r_item.data_value);
                mul_b = bnu_pkg::MUL_B_W'(mem_rd.weight);
            end
            bnu_pkg::S_HID_MUL: begin
                mul_a = bnu_pkg::MUL_A_W'(r_item.data_value);
                mul_b = bnu_pkg::MUL_B_W'(r_item.downstream_weight);
            end
            bnu_pkg::S_DER_MUL: begin
                mul_a = bnu_pkg::MUL_A_W'(r_out);
                mul_b = bnu_pkg::MUL_B_W'(r_out);
            end
            bnu_pkg::S_GRAD_MUL: begin
                if (r_item.mode == bnu_pkg::MODE_OUT_GRAD) begin
                    mul_a = bnu_pkg::MUL_A_W'(delta);
                end else begin
                    mul_a = bnu_pkg::MUL_A_W'(acc_q);
                end
                mul_b = bnu_pkg::MUL_B_W'(r_d);
            end
            bnu_pkg::S_UPD_MUL1: begin
                mul_a = bnu_pkg::MUL_A_W'(signed'({1'b0, r_eta}));
                mul_b = bnu_pkg::MUL_B_W'(r_item.data_value);
            end
            bnu_pkg::S_UPD_MUL2: begin
                mul_a = bnu_pkg::MUL_A_W'(prod);
                mul_b = bnu_pkg::MUL_B_W'(r_grad);
            end
            bnu_pkg::S_UPD_MUL3: begin
                mul_a = bnu_pkg::MUL_A_W'(signed'({1'b0, r_alpha}));
                mul_b = bnu_pkg::MUL_B_W'(mem_rd.change);
            end
            default: begin
            end
        endcase
    end

    // Sequencer: next state and register updates.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_acc       = r_acc;
        n_out       = r_out;
        n_grad      = r_grad;
        n_d         = r_d;
        n_step      = r_step;
        n_chg       = r_chg;
        n_res       = r_res;
        n_clip      = r_clip;
        n_kind      = r_kind;
        n_ridx      = r_ridx;
        n_eta       = r_eta;
        n_alpha     = r_alpha;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        mem_wr      = '{we: 1'b0, addr: slot, data: '{change: r_chg, weight: w_sat.value}};

        // The user must issue register writes only while idle; the block does not enforce it.
        if (i_cfg_we) begin
            case (bnu_pkg::t_cfg_idx'(i_cfg_index))
                bnu_pkg::CFG_LEARNING_RATE: n_eta   = i_cfg_wdata;
                bnu_pkg::CFG_MOMENTUM:      n_alpha = i_cfg_wdata;
                default: begin
                end
            endcase
        end

        case (r_state)
            bnu_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_item = i_in_data;
                    n_clip = 1'b0;
                    n_ridx = '0;
                    case (bnu_pkg::t_mode'(i_in_data.mode))
                        bnu_pkg::MODE_FORWARD:  n_state = bnu_pkg::S_READ;
                        bnu_pkg::MODE_OUT_GRAD: n_state = bnu_pkg::S_DER_MUL;
                        bnu_pkg::MODE_HID_GRAD: n_state = bnu_pkg::S_HID_MUL;
                        bnu_pkg::MODE_UPDATE:   n_state = bnu_pkg::S_READ;
                        default:                n_state = bnu_pkg::S_IDLE;
                    endcase
                end
            end
            // Wait for the registered slot store read.
            bnu_pkg::S_READ: begin
                if (r_item.mode == bnu_pkg::MODE_FORWARD) begin
                    n_state = bnu_pkg::S_FWD_MUL;
                end else begin
                    n_state = bnu_pkg::S_UPD_MUL1;
                end
            end
            bnu_pkg::S_FWD_MUL: begin
                n_state = bnu_pkg::S_FWD_ACC;
            end
            bnu_pkg::S_FWD_ACC: begin
                n_acc   = acc_sat;
                n_state = r_item.last_element ? bnu_pkg::S_TANH : bnu_pkg::S_IDLE;
            end
            // The lookup registers the freshly summed accumulator here.
            bnu_pkg::S_TANH: begin
                n_state = bnu_pkg::S_TANH_WR;
            end
            bnu_pkg::S_TANH_WR: begin
                n_out   = tanh_y;
                n_res   = tanh_y;
                n_kind  = bnu_pkg::KIND_OUTPUT;
                n_acc   = '0;
                n_state = bnu_pkg::S_FIN;
            end
            bnu_pkg::S_HID_MUL: begin
                n_state = bnu_pkg::S_HID_ACC;
            end
            bnu_pkg::S_HID_ACC: begin
                n_acc   = acc_sat;
                n_state = r_item.last_element ? bnu_pkg::S_DER_MUL : bnu_pkg::S_IDLE;
            end
            // Derivative of tanh: one minus output squared.
            bnu_pkg::S_DER_MUL: begin
                n_state = bnu_pkg::S_DER_SUB;
            end
            bnu_pkg::S_DER_SUB: begin
                n_d     = ONE_D - bnu_pkg::DER_W'(prod >>> bnu_pkg::FRAC_BITS);
                n_state = bnu_pkg::S_GRAD_MUL;
            end
            bnu_pkg::S_GRAD_MUL: begin
                n_state = bnu_pkg::S_GRAD_SAT;
            end
            bnu_pkg::S_GRAD_SAT: begin
                n_grad  = grad_sat.value;
                n_res   = grad_sat.value;
                n_clip  = grad_sat.clip;
                n_kind  = bnu_pkg::KIND_GRADIENT;
                if (r_item.mode == bnu_pkg::MODE_HID_GRAD) begin
                    n_acc = '0;
                end
                n_state = bnu_pkg::S_FIN;
            end
            // Weight update: eta*act, then times gradient, then alpha*last change.
            bnu_pkg::S_UPD_MUL1: begin
                n_state = bnu_pkg::S_UPD_MUL2;
            end
            bnu_pkg::S_UPD_MUL2: begin
                n_state = bnu_pkg::S_UPD_MUL3;
            end
            bnu_pkg::S_UPD_MUL3: begin
                n_step  = bnu_pkg::STEP_W'(prod >>> (2 * bnu_pkg::FRAC_BITS));
                n_state = bnu_pkg::S_UPD_CHG;
            end
            bnu_pkg::S_UPD_CHG: begin
                n_chg   = chg_sat.value;
                n_clip  = chg_sat.clip;
                n_state = bnu_pkg::S_UPD_WR;
            end
            bnu_pkg::S_UPD_WR: begin
                mem_wr.we = 1'b1;
                n_res     = w_sat.value;
                n_clip    = r_clip || w_sat.clip;
                n_kind    = bnu_pkg::KIND_WEIGHT;
                n_ridx    = bnu_pkg::INDEX_W'(slot);
                n_state   = bnu_pkg::S_FIN;
            end
            // Hold the result until the output register is free.
            bnu_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{result_value: r_res, result_kind: r_kind,
                                    result_index: r_ridx, saturated: r_clip};
                    n_state     = bnu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bnu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bnu_pkg::S_IDLE;
            r_acc       <= '0;
            r_out       <= '0;
            r_grad      <= '0;
            r_eta       <= bnu_pkg::LR_RESET;
            r_alpha     <= bnu_pkg::MOM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out       <= n_out;
            r_grad      <= n_grad;
            r_eta       <= n_eta;
            r_alpha     <= n_alpha;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_d        <= n_d;
        r_step     <= n_step;
        r_chg      <= n_chg;
        r_res      <= n_res;
        r_clip     <= n_clip;
        r_kind     <= n_kind;
        r_ridx     <= n_ridx;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> design/bnu_mul.sv
// Shared signed multiplier with a registered product.
module bnu_mul (
    input  logic                                i_clk,
    input  logic signed [bnu_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [bnu_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [bnu_pkg::PROD_W-1:0]   o_prod
);

    logic signed [bnu_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= bnu_pkg::PROD_W'(i_a) * bnu_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> design/bnu_mem.sv
// Per-slot weight and last-change store, set to its reset values by a pass after reset.
module bnu_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bnu_pkg::t_mem_wr              i_wr,
    input  logic [bnu_pkg::SLOT_W-1:0]    i_raddr,
    output bnu_pkg::t_mem_word            o_rdata,
    output logic                          o_busy
);

    bnu_pkg::t_mem_word               r_mem [bnu_pkg::MAX_INPUTS];
    bnu_pkg::t_mem_word               r_rdata;
    logic                             r_busy;
    logic [bnu_pkg::SLOT_W-1:0]       r_clr_addr;

    // Sweep every slot to its reset value, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + bnu_pkg::SLOT_W'(1);
            if (r_clr_addr == bnu_pkg::SLOT_W'(bnu_pkg::MAX_INPUTS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '{change: '0, weight: bnu_pkg::WEIGHT_RESET};
        end else if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

>>> design/bnu_tanh.sv
// Registered tanh lookup of the accumulator, with saturation to one.
module bnu_tanh (
    input  logic                                i_clk,
    input  logic signed [bnu_pkg::ACC_W-1:0]    i_acc,
    output logic signed [bnu_pkg::DATA_W-1:0]   o_y
);

    localparam bnu_pkg::t_tanh_tab TANH_TAB = bnu_pkg::build_tanh();
    localparam logic [bnu_pkg::ACC_Q_W-1:0] LIMIT =
        bnu_pkg::ACC_Q_W'(bnu_pkg::TANH_SPAN) << bnu_pkg::FRAC_BITS;
    localparam int IDX_TOP = bnu_pkg::FRAC_BITS + bnu_pkg::TANH_SPAN_LOG2 - 1;

    logic signed [bnu_pkg::ACC_Q_W-1:0]     x;
    logic [bnu_pkg::ACC_Q_W-1:0]            mag;
    logic [bnu_pkg::TANH_DEPTH_LOG2-1:0]    idx;
    logic signed [bnu_pkg::DATA_W-1:0]      mag_y;
    logic signed [bnu_pkg::DATA_W-1:0]      r_y;

    always_comb begin
        x     = bnu_pkg::ACC_Q_W'(i_acc >>> bnu_pkg::FRAC_BITS);
        mag   = x[bnu_pkg::ACC_Q_W-1] ? bnu_pkg::ACC_Q_W'(-x) : bnu_pkg::ACC_Q_W'(x);
        idx   = mag[IDX_TOP -: bnu_pkg::TANH_DEPTH_LOG2];
        if (mag >= LIMIT) begin
            mag_y = bnu_pkg::DATA_W'(1 << bnu_pkg::FRAC_BITS);
        end else begin
            mag_y = bnu_pkg::DATA_W'(TANH_TAB[idx]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= x[bnu_pkg::ACC_Q_W-1] ? -mag_y : mag_y;
    end

    assign o_y = r_y;

endmodule

>>> tb/sv/backprop_neuron_unit_test.sv
// Self-checking testbench for the backpropagation neuron unit.
module backprop_neuron_unit_test;

    import bnu_pkg::*;

    // Give up after this many cycles with no transaction on either channel.
    localparam int     STALL_LIMIT = 2000;
    // Each random phase stops once this many transactions have been sent.
    localparam int     PHASE_ITEMS = 102;
    localparam longint UNITY       = longint'(1) <<< FRAC_BITS;
    localparam longint ACC_TOP     = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_BOTTOM  = -(longint'(1) <<< (ACC_W - 1));
    localparam longint TANH_EDGE   = longint'(TANH_SPAN) <<< FRAC_BITS;

    // Shadow copy of the neuron: works out the result of every accepted
    // transaction and holds it until the unit delivers one.
    class neuron_scoreboard;
        logic signed [DATA_W-1:0] weight [MAX_INPUTS];
        logic signed [DATA_W-1:0] change [MAX_INPUTS];
        logic [TANH_W-1:0]        tanh_mag [TANH_DEPTH];
        logic signed [DATA_W-1:0] neuron_out;
        logic signed [DATA_W-1:0] neuron_grad;
        logic [CFG_W-1:0]         eta;
        logic [CFG_W-1:0]         alpha;
        longint                   acc;
        t_out_item                awaited [$];
        int                       errors;

        function new();
            bit [63:0] one32;
            bit [63:0] inc;
            bit [63:0] pos;
            bit [63:0] neg;
            bit [63:0] term;
            bit [63:0] base;
            bit [63:0] p;
            bit [63:0] num;
            bit [63:0] den;
            // e^-t by series in Q32, then tanh = (1 - e^-2x) / (1 + e^-2x)
            one32 = 64'd1 << 32;
            inc   = (64'(2 * TANH_SPAN) << 32) / 64'(TANH_DEPTH);
            pos   = one32;
            neg   = '0;
            term  = one32;
            for (int k = 1; k <= 24; k++) begin
                term = ((term * inc) >> 32) / 64'(k);
                if (k % 2 == 1) begin
                    neg += term;
                end else begin
                    pos += term;
                end
            end
            base = pos - neg;
            p    = one32;
            for (int i = 0; i < TANH_DEPTH; i++) begin
                num         = one32 - p;
                den         = one32 + p;
                tanh_mag[i] = TANH_W'(((num << FRAC_BITS) + (den >> 1)) / den);
                p           = (p * base) >> 32;
            end
            foreach (weight[i]) begin
                weight[i] = WEIGHT_RESET;
                change[i] = '0;
            end
            neuron_out  = '0;
            neuron_grad = '0;
            eta         = LR_RESET;
            alpha       = MOM_RESET;
            acc         = 0;
            errors      = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
            if (idx == CFG_LEARNING_RATE) begin
                eta = value;
            end else begin
                alpha = value;
            end
        endfunction

        function logic signed [DATA_W-1:0] clip16(longint v, inout bit clip);
            if (v > 32767) begin
                clip = 1'b1;
                return 16'sh7FFF;
            end
            if (v < -32768) begin
                clip = 1'b1;
                return 16'sh8000;
            end
            return DATA_W'(v);
        endfunction

        function void accumulate(longint v);
            acc = acc + v;
            if (acc > ACC_TOP) acc = ACC_TOP;
            if (acc < ACC_BOTTOM) acc = ACC_BOTTOM;
        endfunction

        // 1 - out^2 in Q4.12
        function longint slope();
            return UNITY - ((longint'(neuron_out) * longint'(neuron_out)) >>> FRAC_BITS);
        endfunction

        function logic signed [DATA_W-1:0] squash(longint sum);
            longint x;
            longint m;
            longint y;
            x = sum >>> FRAC_BITS;
            m = (x < 0) ? -x : x;
            y = (m >= TANH_EDGE) ? UNITY : longint'(tanh_mag[(m * TANH_DEPTH) / TANH_EDGE]);
            return DATA_W'((x < 0) ? -y : y);
        endfunction

        function void take_item(t_in_item item);
            t_out_item res;
            longint    data;
            longint    dw;
            longint    grad_step;
            longint    mom_part;
            int        slot;
            bit        clip;
            data = longint'($signed(item.data_value));
            dw   = longint'($signed(item.downstream_weight));
            slot = int'(item.element_index) % MAX_INPUTS;
            clip = 1'b0;
            res  = '0;
            case (t_mode'(item.mode))
                MODE_FORWARD: begin
                    accumulate(data * longint'(weight[slot]));
                    if (!item.last_element) return;
                    neuron_out       = squash(acc);
                    acc              = 0;
                    res.result_value = neuron_out;
                    res.result_kind  = KIND_OUTPUT;
                end
                MODE_OUT_GRAD: begin
                    neuron_grad = clip16(((data - longint'(neuron_out)) * slope()) >>> FRAC_BITS,
                                         clip);
                    res.result_value = neuron_grad;
                    res.result_kind  = KIND_GRADIENT;
                end
                MODE_HID_GRAD: begin
                    accumulate(data * dw);
                    if (!item.last_element) return;
                    neuron_grad = clip16(((acc >>> FRAC_BITS) * slope()) >>> FRAC_BITS, clip);
                    acc              = 0;
                    res.result_value = neuron_grad;
                    res.result_kind  = KIND_GRADIENT;
                end
                default: begin
                    grad_step = (longint'(eta) * data * longint'(neuron_grad)) >>> (2 * FRAC_BITS);
                    mom_part  = (longint'(alpha) * longint'(change[slot])) >>> FRAC_BITS;
                    change[slot] = clip16(grad_step + mom_part, clip);
                    weight[slot] = clip16(longint'(weight[slot]) + longint'(change[slot]), clip);
                    res.result_value = weight[slot];
                    res.result_kind  = KIND_WEIGHT;
                    res.result_index = INDEX_W'(slot);
                end
            endcase
            res.saturated = clip;
            awaited = {awaited, res};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %0d kind %0d index %0d sat %0b",
                             got.result_value, got.result_kind, got.result_index,
                             got.saturated);
                return;
            end
            want = awaited.pop_front();
            if (got.result_value !== want.result_value || got.result_kind !== want.result_kind ||
                got.result_index !== want.result_index || got.saturated !== want.saturated) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected value %0d kind %0d index %0d sat %0b, %s",
                             want.result_value, want.result_kind, want.result_index,
                             want.saturated,
                             $sformatf("got value %0d kind %0d index %0d sat %0b",
                                       got.result_value, got.result_kind, got.result_index,
                                       got.saturated));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_wdata;

    neuron_scoreboard sb = new();
    // High while neither side idles nor stalls at random.
    bit               steady;
    int               sent;

    backprop_neuron_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver side: stall at random about 19 percent of the time, never while steady.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = !steady && ($urandom_range(99) < 19);
        end
    end

    // Observe every handshake at the rising edge: configuration writes, accepted
    // input transactions and delivered results all go through the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(t_cfg_idx'(i_cfg_index), i_cfg_wdata);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
            if (i_in_valid && !o_in_stall)
                sb.take_item(i_in_data);
        end
    end

    // Watchdog: end the run when the channels have been quiet for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // Offer one transaction. Enter and leave at a falling edge; idle at random
    // beforehand, then hold the payload until the unit takes it.
    task automatic send(t_mode m, int data, int dw, int slot, bit last);
        while (!steady && $urandom_range(99) < 19) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid                  = 1'b1;
        i_in_data.mode              = m;
        i_in_data.data_value        = DATA_W'(data);
        i_in_data.downstream_weight = DATA_W'(dw);
        i_in_data.element_index     = INDEX_W'(slot);
        i_in_data.last_element      = last;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        @(negedge i_clk);
    endtask

    // Program both registers once the unit has drained. Elements without the
    // last mark give no result, so wait past the longest transaction before
    // touching the registers.
    task automatic write_config(int eta, int alpha);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_LEARNING_RATE;
        i_cfg_wdata = CFG_W'(eta);
        @(negedge i_clk);
        i_cfg_index = CFG_MOMENTUM;
        i_cfg_wdata = CFG_W'(alpha);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Mostly full-range words, with a share of small values that keep tanh off
    // its rails and a share of the extremes.
    function automatic int rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return int'($urandom);
        if (pick < 80) return int'($urandom_range(8191)) - 4096;
        case ($urandom_range(4))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            3:       return 1;
            default: return -1;
        endcase
    endfunction

    // Favour a few slots so that momentum builds up on them.
    function automatic int pick_slot();
        return ($urandom_range(1) == 0) ? int'($urandom_range(7)) : int'($urandom_range(63));
    endfunction

    // One training step fragment with random content; a small share is noise.
    task automatic random_sequence();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 30) begin
            len = $urandom_range(1, 6);
            for (int n = 0; n < len; n++)
                send(MODE_FORWARD, rand_word(), rand_word(), pick_slot(), n == len - 1);
        end else if (pick < 45) begin
            send(MODE_OUT_GRAD, rand_word(), rand_word(), $urandom_range(63),
                 1'($urandom_range(1)));
        end else if (pick < 65) begin
            len = $urandom_range(1, 5);
            for (int n = 0; n < len; n++)
                send(MODE_HID_GRAD, rand_word(), rand_word(), $urandom_range(63), n == len - 1);
        end else if (pick < 88) begin
            len = $urandom_range(1, 4);
            for (int n = 0; n < len; n++)
                send(MODE_UPDATE, rand_word(), rand_word(), pick_slot(),
                     1'($urandom_range(1)));
        end else begin
            len = $urandom_range(1, 3);
            for (int n = 0; n < len; n++)
                send(t_mode'($urandom_range(3)), int'($urandom), int'($urandom),
                     $urandom_range(63), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        int start;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_LEARNING_RATE;
        i_cfg_wdata = '0;
        steady      = 1'b0;
        sent        = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset settings. Short forward run over extreme
        // activations and both ends of the slot range.
        send(MODE_FORWARD, 32767, 0, 0, 1'b0);
        send(MODE_FORWARD, -32768, -1, 63, 1'b0);
        send(MODE_FORWARD, 0, 32767, 1, 1'b1);
        // Output gradient against extreme targets.
        send(MODE_OUT_GRAD, 32767, 0, 0, 1'b0);
        send(MODE_OUT_GRAD, -32768, 0, 63, 1'b1);
        // Hidden gradient run over extreme downstream weights.
        send(MODE_HID_GRAD, 32767, -32768, 0, 1'b0);
        send(MODE_HID_GRAD, -32768, 32767, 63, 1'b0);
        send(MODE_HID_GRAD, -32768, -32768, 5, 1'b1);
        // Updates; the repeat on slot 0 goes through the momentum term.
        send(MODE_UPDATE, 32767, 0, 0, 1'b0);
        send(MODE_UPDATE, -32768, 0, 63, 1'b1);
        send(MODE_UPDATE, 32767, 0, 0, 1'b0);
        // Sums well past the table span: tanh pinned at plus and minus one.
        for (int n = 0; n < 4; n++)
            send(MODE_FORWARD, 32767, 0, 2 + n, n == 3);
        send(MODE_OUT_GRAD, 0, 0, 0, 1'b0);
        for (int n = 0; n < 4; n++)
            send(MODE_FORWARD, -32768, 0, 2 + n, n == 3);
        // Forward and hidden elements mixed within one run.
        send(MODE_FORWARD, 4096, 0, 7, 1'b0);
        send(MODE_HID_GRAD, 4096, -8192, 0, 1'b0);
        send(MODE_FORWARD, 100, 0, 8, 1'b1);
        send(MODE_UPDATE, 0, 0, 9, 1'b0);
        send(MODE_HID_GRAD, 0, 0, 0, 1'b1);

        // Random phases, each under its own register setting. Phase 1 runs
        // with no idling at all.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_config(0, 0);
                1: write_config(4096, 8191);
                2: write_config(LR_RESET, MOM_RESET);
                3: write_config($urandom_range(4096), $urandom_range(8191));
                4: write_config(4096, 0);
                default: write_config($urandom_range(1, 4096), 8191);
            endcase
            steady = (phase == 1);
            start  = sent;
            while (sent - start < PHASE_ITEMS)
                random_sequence();
        end

        // Drain, then give stray results a chance to show up.
        i_in_valid = 1'b0;
        steady     = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> backprop_neuron_unit.f
design/bnu_pkg.sv
design/bnu_mul.sv
design/bnu_mem.sv
design/bnu_tanh.sv
design/backprop_neuron_unit.sv
tb/sv/backprop_neuron_unit_test.sv
